/* rtl/qft_pkg.sv */
// Shared types and constants for the shortest-arc quaternion block.
`default_nettype none

package qft_pkg;

    localparam int QFT_COMP_BITS = 16;
    localparam int QFT_RES_BITS  = 16;
    localparam int QFT_FRAC_BITS = QFT_RES_BITS - 2;

    localparam int QFT_ISQ_IN_BITS  = 64;
    localparam int QFT_ISQ_OUT_BITS = QFT_ISQ_IN_BITS / 2;
    localparam int QFT_ISQ_STAGES   = QFT_ISQ_OUT_BITS;

    localparam int QFT_DIV_QUO_BITS = QFT_FRAC_BITS + 1;
    localparam int QFT_DIV_DEN_BITS = 32;
    localparam int QFT_DIV_NUM_BITS = 31 + QFT_FRAC_BITS;
    localparam int QFT_DIV_STAGES   = QFT_DIV_QUO_BITS;

    typedef struct packed {
        logic signed [QFT_COMP_BITS-1:0] u_x;
        logic signed [QFT_COMP_BITS-1:0] u_y;
        logic signed [QFT_COMP_BITS-1:0] u_z;
        logic signed [QFT_COMP_BITS-1:0] v_x;
        logic signed [QFT_COMP_BITS-1:0] v_y;
        logic signed [QFT_COMP_BITS-1:0] v_z;
        logic signed [QFT_COMP_BITS-1:0] fallback_x;
        logic signed [QFT_COMP_BITS-1:0] fallback_y;
        logic signed [QFT_COMP_BITS-1:0] fallback_z;
    } t_qft_in;

    typedef struct packed {
        logic signed [QFT_RES_BITS-1:0] quat_w;
        logic signed [QFT_RES_BITS-1:0] quat_x;
        logic signed [QFT_RES_BITS-1:0] quat_y;
        logic signed [QFT_RES_BITS-1:0] quat_z;
        logic                           opposite_case;
        logic                           degenerate;
    } t_qft_out;

endpackage

`default_nettype wire

/* rtl/qft_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
`default_nettype none

module qft_isqrt (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    input  wire logic [qft_pkg::QFT_ISQ_IN_BITS-1:0]  i_value,
    output logic                                      o_valid,
    output logic      [qft_pkg::QFT_ISQ_OUT_BITS-1:0] o_root
);
    import qft_pkg::*;

    logic [QFT_ISQ_IN_BITS-1:0]  r_rem  [QFT_ISQ_STAGES];
    logic [QFT_ISQ_OUT_BITS-1:0] r_root [QFT_ISQ_STAGES];
    logic [QFT_ISQ_STAGES-1:0]   r_vld;

    for (genvar k = 0; k < QFT_ISQ_STAGES; k++) begin : g_stage
        localparam int B = QFT_ISQ_STAGES - 1 - k;
        logic [QFT_ISQ_IN_BITS-1:0]  rem_i;
        logic [QFT_ISQ_OUT_BITS-1:0] root_i;
        logic [QFT_ISQ_IN_BITS+1:0]  trial;
        logic                        take;

        if (k == 0) begin : g_first
            assign rem_i  = i_value;
            assign root_i = '0;
        end else begin : g_next
            assign rem_i  = r_rem[k-1];
            assign root_i = r_root[k-1];
        end

        assign trial = ({{(QFT_ISQ_IN_BITS+2-QFT_ISQ_OUT_BITS){1'b0}}, root_i} << (B + 1))
                     + ({{(QFT_ISQ_IN_BITS+1){1'b0}}, 1'b1} << (2 * B));
        assign take  = {2'b00, rem_i} >= trial;

        always_ff @(posedge i_clk) begin
            if (take) begin
                r_rem[k]  <= rem_i - trial[QFT_ISQ_IN_BITS-1:0];
                r_root[k] <= root_i | ({{(QFT_ISQ_OUT_BITS-1){1'b0}}, 1'b1} << B);
            end else begin
                r_rem[k]  <= rem_i;
                r_root[k] <= root_i;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[QFT_ISQ_STAGES-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[QFT_ISQ_STAGES-1];
    assign o_root  = r_root[QFT_ISQ_STAGES-1];

endmodule

`default_nettype wire

/* rtl/qft_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module qft_div (
    input  wire logic                                 i_clk,
    input  wire logic [qft_pkg::QFT_DIV_NUM_BITS-1:0] i_num,
    input  wire logic [qft_pkg::QFT_DIV_DEN_BITS-1:0] i_den,
    output logic      [qft_pkg::QFT_DIV_QUO_BITS-1:0] o_quo
);
    import qft_pkg::*;

    localparam int TW = QFT_DIV_NUM_BITS + 1;

    logic [QFT_DIV_NUM_BITS-1:0] r_rem [QFT_DIV_STAGES];
    logic [QFT_DIV_DEN_BITS-1:0] r_den [QFT_DIV_STAGES];
    logic [QFT_DIV_QUO_BITS-1:0] r_quo [QFT_DIV_STAGES];

    for (genvar k = 0; k < QFT_DIV_STAGES; k++) begin : g_stage
        localparam int B = QFT_DIV_STAGES - 1 - k;
        logic [QFT_DIV_NUM_BITS-1:0] rem_i;
        logic [QFT_DIV_DEN_BITS-1:0] den_i;
        logic [QFT_DIV_QUO_BITS-1:0] quo_i;
        logic [TW-1:0]               trial;
        logic [TW-1:0]               diff;
        logic                        take;

        if (k == 0) begin : g_first
            assign rem_i = i_num;
            assign den_i = i_den;
            assign quo_i = '0;
        end else begin : g_next
            assign rem_i = r_rem[k-1];
            assign den_i = r_den[k-1];
            assign quo_i = r_quo[k-1];
        end

        assign trial = {{(TW-QFT_DIV_DEN_BITS){1'b0}}, den_i} << B;
        assign take  = {1'b0, rem_i} >= trial;
        assign diff  = {1'b0, rem_i} - trial;

        always_ff @(posedge i_clk) begin
            r_den[k] <= den_i;
            if (take) begin
                r_rem[k] <= diff[QFT_DIV_NUM_BITS-1:0];
                r_quo[k] <= quo_i | ({{(QFT_DIV_QUO_BITS-1){1'b0}}, 1'b1} << B);
            end else begin
                r_rem[k] <= rem_i;
                r_quo[k] <= quo_i;
            end
        end
    end

    assign o_quo = r_quo[QFT_DIV_STAGES-1];

endmodule

`default_nettype wire

/* rtl/quaternion_from_two_vectors.sv */
// Top level: shortest-arc unit quaternion from two vectors, fully pipelined.
//
// Input: i_data carries source u, target v and a fallback axis, all signed Q8.8.
// An item is transferred at a rising edge with i_start high and o_busy low.
// o_busy is always low: the pipeline takes one item in every cycle.
// Output: o_result carries the quaternion in signed Q2.14 plus the opposite
// and degenerate flags; o_valid marks it for exactly one cycle.
// Every item passes through the same stages; throughput is one item per cycle.
// The pipeline is made of two 32-stage square root units (norm product and
// quaternion length), a 15-stage divider per component and 13 stages of
// products, sums, case selection, scaling and output.
// Reset clears all valid bits; items in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module quaternion_from_two_vectors (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire qft_pkg::t_qft_in  i_data,
    output logic                   o_busy,
    output logic                   o_valid,
    output qft_pkg::t_qft_out      o_result
);
    import qft_pkg::*;

    localparam int QFT_LATENCY = 2 * QFT_ISQ_STAGES + QFT_DIV_STAGES + 13;
    localparam logic [33:0] T1 = 34'h040000001;

    typedef struct packed {
        logic signed [32:0] dot;
        logic signed [32:0] cx;
        logic signed [32:0] cy;
        logic signed [32:0] cz;
        logic signed [16:0] ox;
        logic signed [16:0] oy;
        logic signed [16:0] oz;
    } t_side1;

    typedef struct packed {
        logic [3:0][30:0] mag;
        logic [3:0]       sg;
        logic             opp;
    } t_side2;

    typedef struct packed {
        logic [3:0] sg;
        logic       opp;
        logic       deg;
    } t_side3;

    function automatic logic [1:0] f_shamt(input logic [33:0] m);
        logic [1:0] s;
        if (m < T1) s = 2'd0;
        else if (m < {T1[32:0], 1'b0}) s = 2'd1;
        else if (m < {T1[31:0], 2'b00}) s = 2'd2;
        else s = 2'd3;
        return s;
    endfunction

    logic r_v1, r_v2, r_v3, r_v4;
    logic r_ve1, r_ve2, r_ve3, r_ve4, r_ve5, r_ve6, r_ve7;
    logic r_vd1, r_vo;
    logic [QFT_DIV_STAGES-1:0] r_vq;
    logic w_vn, w_vl;

    t_qft_in            r_in;
    logic signed [31:0] r_pu [3];
    logic signed [31:0] r_pv [3];
    logic signed [31:0] r_pd [3];
    logic signed [31:0] r_pc [6];
    logic signed [16:0] r_ov [3];
    logic signed [16:0] n_ov [3];
    logic signed [16:0] n_ux, n_uy, n_uz;
    logic [16:0]        n_mx, n_mz;

    logic [31:0] r_uu, r_vv;
    t_side1      r_s3, r_s4, n_s3;
    logic [63:0] r_nn;
    t_side1      r_d1 [QFT_ISQ_STAGES];
    logic [QFT_ISQ_OUT_BITS-1:0] w_n;

    logic signed [33:0] r_real;
    logic [31:0]        r_n1;
    t_side1             r_e1;
    logic               n_opp;
    logic signed [33:0] r_q [4];
    logic               r_opp2, r_opp3, r_opp4, r_opp5, r_opp6, r_opp7;
    logic [3:0][33:0]   r_m3, r_m4;
    logic [3:0]         r_sg3, r_sg4, r_sg5, r_sg6, r_sg7;
    logic [1:0]         r_sh, n_sh;
    logic [3:0][30:0]   r_ms5, r_ms6, r_ms7;
    logic [3:0][61:0]   r_sq;
    logic [62:0]        r_sum;
    t_side2             r_d2 [QFT_ISQ_STAGES];
    logic [QFT_ISQ_OUT_BITS-1:0] w_len;

    logic [3:0][QFT_DIV_NUM_BITS-1:0] r_num;
    logic [QFT_DIV_DEN_BITS-1:0]      r_den;
    t_side3                           r_sd1;
    t_side3                           r_d3 [QFT_DIV_STAGES];
    logic [3:0][QFT_DIV_QUO_BITS-1:0] w_quo;
    logic [3:0][QFT_RES_BITS-1:0]     n_sv;
    t_qft_out                         r_out, n_out;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
            r_ve1 <= 1'b0; r_ve2 <= 1'b0; r_ve3 <= 1'b0; r_ve4 <= 1'b0;
            r_ve5 <= 1'b0; r_ve6 <= 1'b0; r_ve7 <= 1'b0;
            r_vd1 <= 1'b0; r_vq <= '0; r_vo <= 1'b0;
        end else begin
            r_v1 <= i_start && !o_busy;
            r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3;
            r_ve1 <= w_vn; r_ve2 <= r_ve1; r_ve3 <= r_ve2; r_ve4 <= r_ve3;
            r_ve5 <= r_ve4; r_ve6 <= r_ve5; r_ve7 <= r_ve6;
            r_vd1 <= w_vl;
            r_vq  <= {r_vq[QFT_DIV_STAGES-2:0], r_vd1};
            r_vo  <= r_vq[QFT_DIV_STAGES-1];
        end
    end

    always_comb begin
        n_ux = 17'(r_in.u_x);
        n_uy = 17'(r_in.u_y);
        n_uz = 17'(r_in.u_z);
        n_mx = n_ux[16] ? 17'(-n_ux) : n_ux;
        n_mz = n_uz[16] ? 17'(-n_uz) : n_uz;
        if (r_in.fallback_x != '0 || r_in.fallback_y != '0 || r_in.fallback_z != '0) begin
            n_ov[0] = 17'(r_in.fallback_x);
            n_ov[1] = 17'(r_in.fallback_y);
            n_ov[2] = 17'(r_in.fallback_z);
        end else if (n_mx > n_mz) begin
            n_ov[0] = -n_uy;
            n_ov[1] = n_ux;
            n_ov[2] = '0;
        end else begin
            n_ov[0] = '0;
            n_ov[1] = -n_uz;
            n_ov[2] = n_uy;
        end
    end

    always_comb begin
        n_s3.dot = 33'(r_pd[0]) + 33'(r_pd[1]) + 33'(r_pd[2]);
        n_s3.cx  = 33'(r_pc[0]) - 33'(r_pc[1]);
        n_s3.cy  = 33'(r_pc[2]) - 33'(r_pc[3]);
        n_s3.cz  = 33'(r_pc[4]) - 33'(r_pc[5]);
        n_s3.ox  = r_ov[0];
        n_s3.oy  = r_ov[1];
        n_s3.oz  = r_ov[2];
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_data;
        r_pu[0] <= r_in.u_x * r_in.u_x;
        r_pu[1] <= r_in.u_y * r_in.u_y;
        r_pu[2] <= r_in.u_z * r_in.u_z;
        r_pv[0] <= r_in.v_x * r_in.v_x;
        r_pv[1] <= r_in.v_y * r_in.v_y;
        r_pv[2] <= r_in.v_z * r_in.v_z;
        r_pd[0] <= r_in.u_x * r_in.v_x;
        r_pd[1] <= r_in.u_y * r_in.v_y;
        r_pd[2] <= r_in.u_z * r_in.v_z;
        r_pc[0] <= r_in.u_y * r_in.v_z;
        r_pc[1] <= r_in.u_z * r_in.v_y;
        r_pc[2] <= r_in.u_z * r_in.v_x;
        r_pc[3] <= r_in.u_x * r_in.v_z;
        r_pc[4] <= r_in.u_x * r_in.v_y;
        r_pc[5] <= r_in.u_y * r_in.v_x;
        r_ov[0] <= n_ov[0];
        r_ov[1] <= n_ov[1];
        r_ov[2] <= n_ov[2];
        r_uu <= $unsigned(r_pu[0]) + $unsigned(r_pu[1]) + $unsigned(r_pu[2]);
        r_vv <= $unsigned(r_pv[0]) + $unsigned(r_pv[1]) + $unsigned(r_pv[2]);
        r_s3 <= n_s3;
        r_nn <= r_uu * r_vv;
        r_s4 <= r_s3;
        r_d1[0] <= r_s4;
        for (int k = 1; k < QFT_ISQ_STAGES; k++) begin
            r_d1[k] <= r_d1[k-1];
        end
    end

    qft_isqrt u_isqrt_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .i_value (r_nn),
        .o_valid (w_vn),
        .o_root  (w_n)
    );

    assign n_opp = $signed({r_real, 20'd0}) < $signed({22'd0, r_n1});

    always_comb begin
        n_sh = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (f_shamt(r_m3[i]) > n_sh) n_sh = f_shamt(r_m3[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_real <= $signed({2'b00, w_n}) + 34'(r_d1[QFT_ISQ_STAGES-1].dot);
        r_n1   <= w_n;
        r_e1   <= r_d1[QFT_ISQ_STAGES-1];
        r_opp2 <= n_opp;
        if (n_opp) begin
            r_q[0] <= '0;
            r_q[1] <= 34'(r_e1.ox);
            r_q[2] <= 34'(r_e1.oy);
            r_q[3] <= 34'(r_e1.oz);
        end else begin
            r_q[0] <= r_real;
            r_q[1] <= 34'(r_e1.cx);
            r_q[2] <= 34'(r_e1.cy);
            r_q[3] <= 34'(r_e1.cz);
        end
        for (int i = 0; i < 4; i++) begin
            r_m3[i]  <= r_q[i][33] ? $unsigned(-r_q[i]) : $unsigned(r_q[i]);
            r_sg3[i] <= r_q[i][33];
        end
        r_opp3 <= r_opp2;
        r_m4   <= r_m3;
        r_sg4  <= r_sg3;
        r_opp4 <= r_opp3;
        r_sh   <= n_sh;
        for (int i = 0; i < 4; i++) begin
            r_ms5[i] <= 31'(r_m4[i] >> r_sh);
        end
        r_sg5  <= r_sg4;
        r_opp5 <= r_opp4;
        for (int i = 0; i < 4; i++) begin
            r_sq[i] <= r_ms5[i] * r_ms5[i];
        end
        r_ms6  <= r_ms5;
        r_sg6  <= r_sg5;
        r_opp6 <= r_opp5;
        r_sum  <= 63'(r_sq[0]) + 63'(r_sq[1]) + 63'(r_sq[2]) + 63'(r_sq[3]);
        r_ms7  <= r_ms6;
        r_sg7  <= r_sg6;
        r_opp7 <= r_opp6;
        r_d2[0] <= '{mag: r_ms7, sg: r_sg7, opp: r_opp7};
        for (int k = 1; k < QFT_ISQ_STAGES; k++) begin
            r_d2[k] <= r_d2[k-1];
        end
    end

    qft_isqrt u_isqrt_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_ve7),
        .i_value ({1'b0, r_sum}),
        .o_valid (w_vl),
        .o_root  (w_len)
    );

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_num[i] <= {r_d2[QFT_ISQ_STAGES-1].mag[i], {QFT_FRAC_BITS{1'b0}}}
                      + QFT_DIV_NUM_BITS'(w_len >> 1);
        end
        r_den     <= w_len;
        r_sd1.sg  <= r_d2[QFT_ISQ_STAGES-1].sg;
        r_sd1.opp <= r_d2[QFT_ISQ_STAGES-1].opp;
        r_sd1.deg <= (w_len == '0);
        r_d3[0]   <= r_sd1;
        for (int k = 1; k < QFT_DIV_STAGES; k++) begin
            r_d3[k] <= r_d3[k-1];
        end
        r_out <= n_out;
    end

    for (genvar i = 0; i < 4; i++) begin : g_lane
        qft_div u_div (
            .i_clk (i_clk),
            .i_num (r_num[i]),
            .i_den (r_den),
            .o_quo (w_quo[i])
        );
        assign n_sv[i] = r_d3[QFT_DIV_STAGES-1].sg[i]
                       ? QFT_RES_BITS'(-{1'b0, w_quo[i]})
                       : QFT_RES_BITS'({1'b0, w_quo[i]});
    end

    always_comb begin
        n_out.opposite_case = r_d3[QFT_DIV_STAGES-1].opp;
        n_out.degenerate    = r_d3[QFT_DIV_STAGES-1].deg;
        if (r_d3[QFT_DIV_STAGES-1].deg) begin
            n_out.quat_w = QFT_RES_BITS'(1) << QFT_FRAC_BITS;
            n_out.quat_x = '0;
            n_out.quat_y = '0;
            n_out.quat_z = '0;
        end else begin
            n_out.quat_w = n_sv[0];
            n_out.quat_x = n_sv[1];
            n_out.quat_y = n_sv[2];
            n_out.quat_z = n_sv[3];
        end
    end

    assign o_valid  = r_vo;
    assign o_result = r_out;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##QFT_LATENCY o_valid)
        else $error("transfer did not produce a result at the expected cycle");

    a_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.degenerate) |->
        (o_result.quat_w == (QFT_RES_BITS'(1) << QFT_FRAC_BITS) && o_result.quat_x == '0
         && o_result.quat_y == '0 && o_result.quat_z == '0))
        else $error("degenerate result is not identity");

    a_opposite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.opposite_case && !o_result.degenerate) |->
        (o_result.quat_w == '0))
        else $error("opposite result has nonzero real part");

endmodule

`default_nettype wire

/* tb/sv/qft_checker.sv */
// Checker for the shortest-arc quaternion block: predicts each result and compares.
`default_nettype none

module qft_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_busy,
    input  wire qft_pkg::t_qft_in  i_data,
    input  wire logic              i_valid,
    input  wire qft_pkg::t_qft_out i_result,
    output int                     o_fail_count,
    output int                     o_pending
);
    import qft_pkg::*;

    t_qft_out quat_queue[$];

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned abs64(longint a);
        return (a < 0) ? longint'(-a) : longint'(a);
    endfunction

    function automatic t_qft_out shortest_arc(t_qft_in d);
        t_qft_out        res;
        longint          ux, uy, uz, vx, vy, vz;
        longint          q[4];
        longint          dot, scalar_part;
        longint unsigned uu, vv, n, big, sum, len, r;
        longint unsigned mg[4];
        int              sh;
        ux = d.u_x; uy = d.u_y; uz = d.u_z;
        vx = d.v_x; vy = d.v_y; vz = d.v_z;
        uu = ux * ux + uy * uy + uz * uz;
        vv = vx * vx + vy * vy + vz * vz;
        n = root_floor(uu * vv);
        dot = ux * vx + uy * vy + uz * vz;
        scalar_part = longint'(n) + dot;
        res = '0;
        if (scalar_part * (64'sd1 <<< 20) < longint'(n)) begin
            res.opposite_case = 1'b1;
            q[0] = 0;
            if (d.fallback_x != 0 || d.fallback_y != 0 || d.fallback_z != 0) begin
                q[1] = d.fallback_x; q[2] = d.fallback_y; q[3] = d.fallback_z;
            end else if (abs64(ux) > abs64(uz)) begin
                q[1] = -uy; q[2] = ux; q[3] = 0;
            end else begin
                q[1] = 0; q[2] = -uz; q[3] = uy;
            end
        end else begin
            q[0] = scalar_part;
            q[1] = uy * vz - uz * vy;
            q[2] = uz * vx - ux * vz;
            q[3] = ux * vy - uy * vx;
        end
        big = 0;
        for (int i = 0; i < 4; i++) begin
            mg[i] = abs64(q[i]);
            if (mg[i] > big) big = mg[i];
        end
        sh = 0;
        while ((big >> sh) > (64'd1 << 30)) sh++;
        sum = 0;
        for (int i = 0; i < 4; i++) begin
            mg[i] >>= sh;
            sum += mg[i] * mg[i];
        end
        len = root_floor(sum);
        if (len == 0) begin
            res.degenerate = 1'b1;
            res.quat_w = 16'sd1 <<< QFT_FRAC_BITS;
        end else begin
            for (int i = 0; i < 4; i++) begin
                r = ((mg[i] << QFT_FRAC_BITS) + (len >> 1)) / len;
                if (q[i] < 0) r = -r;
                case (i)
                    0: res.quat_w = r[15:0];
                    1: res.quat_x = r[15:0];
                    2: res.quat_y = r[15:0];
                    default: res.quat_z = r[15:0];
                endcase
            end
        end
        return res;
    endfunction

    initial o_fail_count = 0;
    assign o_pending = quat_queue.size();

    always @(posedge i_clk) begin
        t_qft_out want;
        if (i_rst_n && i_start && !i_busy) quat_queue.push_back(shortest_arc(i_data));
        if (i_rst_n && i_valid) begin
            if (quat_queue.size() == 0) begin
                $display("%0t: unexpected result got %p", $time, i_result);
                o_fail_count <= o_fail_count + 1;
            end else begin
                want = quat_queue.pop_front();
                if (want !== i_result) begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, i_result);
                    o_fail_count <= o_fail_count + 1;
                end
            end
        end
    end
endmodule

`default_nettype wire

/* tb/sv/tb_quaternion_from_two_vectors.sv */
// Testbench top: drives vector pairs into the quaternion block and gives the verdict.
`default_nettype none

module tb_quaternion_from_two_vectors;
    import qft_pkg::*;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_start = 1'b0;
    t_qft_in  i_data = '0;
    logic     o_busy;
    logic     o_valid;
    t_qft_out o_result;
    int       fail_count;
    int       pending;

    quaternion_from_two_vectors dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_data(i_data),
        .o_busy(o_busy), .o_valid(o_valid), .o_result(o_result)
    );

    qft_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_data(i_data), .i_valid(o_valid), .i_result(o_result),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            3: return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(t_qft_in d, bit idle_gaps);
        int gap;
        gap = idle_gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_data  <= d;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic send_vectors(logic [15:0] ux, logic [15:0] uy, logic [15:0] uz,
                                logic [15:0] vx, logic [15:0] vy, logic [15:0] vz,
                                logic [15:0] fx, logic [15:0] fy, logic [15:0] fz);
        send_item('{ux, uy, uz, vx, vy, vz, fx, fy, fz}, 1'b0);
    endtask

    initial begin
        t_qft_in d;
        int      k;
        bit      gaps;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_vectors(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_vectors(16'd256, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_vectors(16'd256, 16'd0, 16'd0, 16'd256, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_vectors(16'd256, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 16'd0, 16'd0, 16'd0);
        send_vectors(16'd256, 16'd0, 16'd0, 16'hff00, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_vectors(16'd256, 16'd0, 16'd0, 16'hff00, 16'd0, 16'd0, 16'd0, 16'd0, 16'd256);
        send_vectors(16'd0, 16'd0, 16'd256, 16'd0, 16'd0, 16'hfe00, 16'd0, 16'd0, 16'd0);
        send_vectors(16'd0, 16'd300, 16'd100, 16'd0, 16'hfed4, 16'hff9c,
                     16'd0, 16'd0, 16'd0);
        send_vectors(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
                     16'h8000, 16'h7fff, 16'h8000);
        send_vectors(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                     16'd0, 16'd0, 16'd0);
        send_vectors(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                     16'd0, 16'd0, 16'd0);
        send_vectors(16'h8000, 16'd0, 16'd0, 16'h7fff, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_vectors(16'h8000, 16'd0, 16'd0, 16'h7fff, 16'd0, 16'd0,
                     16'hffff, 16'hffff, 16'hffff);
        send_vectors(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
        send_vectors(16'd1, 16'd2, 16'd3, 16'hffff, 16'hfffe, 16'hfffd,
                     16'd0, 16'd0, 16'd0);
        send_vectors(16'd3, 16'd2, 16'd1, 16'hfffd, 16'hfffe, 16'hffff,
                     16'd0, 16'd0, 16'd0);
        send_vectors(16'h7fff, 16'd0, 16'd0, 16'h8000, 16'd0, 16'd0,
                     16'd0, 16'h8000, 16'd0);
        drain();
        for (k = 0; k < 550; k++) begin
            if (k % 100 == 50) begin
                drain();
            end
            gaps = (k / 60) % 2 == 1;
            d.u_x = rand_comp(); d.u_y = rand_comp(); d.u_z = rand_comp();
            case ($urandom_range(0, 3))
                0: begin
                    d.v_x = -d.u_x; d.v_y = -d.u_y; d.v_z = -d.u_z;
                end
                1: begin
                    d.v_x = d.u_x; d.v_y = d.u_y; d.v_z = d.u_z;
                end
                default: begin
                    d.v_x = rand_comp(); d.v_y = rand_comp(); d.v_z = rand_comp();
                end
            endcase
            if ($urandom_range(0, 1)) begin
                d.fallback_x = rand_comp(); d.fallback_y = rand_comp();
                d.fallback_z = rand_comp();
            end else begin
                d.fallback_x = '0; d.fallback_y = '0; d.fallback_z = '0;
            end
            send_item(d, gaps);
        end
        drain();
        repeat (100) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end
endmodule

`default_nettype wire
